FILE: rtl/rmpc_pkg.sv
// ----------------------------------------------------------------------------
// rmpc_pkg
// Shared types, codes and constants of the rover mode PWM commander.
// ----------------------------------------------------------------------------
package rmpc_pkg;

  // Scan and settle set-up
  localparam int SCAN_CHANNELS  = 4;
  localparam int SCAN_W         = (SCAN_CHANNELS > 1) ? $clog2(SCAN_CHANNELS) : 1;
  localparam int SETTLE_SAMPLES = 2;
  localparam int SETTLE_W       = 2;

  // Servo pulse limit and analog scale (7.843 as Q10)
  localparam int          PULSE_LIMIT = 39999;
  localparam logic [15:0] PULSE_MAX   = 16'(PULSE_LIMIT);
  localparam int          SCALE_W     = 13;
  localparam logic [12:0] SCALE_Q10   = 13'd8031;
  localparam int          SCALE_SHIFT = 10;
  localparam int          PROD_W      = 8 + SCALE_W;

  // Input actions
  localparam logic [1:0] ACT_ADC    = 2'd0;
  localparam logic [1:0] ACT_SERIAL = 2'd1;
  localparam logic [1:0] ACT_MODE   = 2'd2;
  localparam logic [1:0] ACT_DIR    = 2'd3;

  // Operating modes
  localparam logic [1:0] MODE_ANALOG = 2'd0;
  localparam logic [1:0] MODE_PRESET = 2'd1;
  localparam logic [1:0] MODE_SERIAL = 2'd2;

  // Serial command selectors
  localparam logic [7:0] SEL_SERVO_A = 8'd1;
  localparam logic [7:0] SEL_SERVO_B = 8'd2;
  localparam logic [7:0] SEL_MOTOR_A = 8'd3;
  localparam logic [7:0] SEL_MOTOR_B = 8'd4;
  localparam logic [7:0] SEL_DIR     = 8'd5;

  // Command values for the direction selector
  localparam logic [7:0] VAL_TOGGLE     = 8'd2;
  localparam logic [7:0] VAL_PRE_PARK   = 8'd4;
  localparam logic [7:0] VAL_PRE_TURN   = 8'd8;
  localparam logic [7:0] VAL_PRE_RIGHT  = 8'd16;
  localparam logic [7:0] VAL_PRE_LEFT   = 8'd32;

  // Configuration register indexes
  localparam int          CFG_IDX_W         = 3;
  localparam logic [2:0]  REG_ANGLE_NINETY  = 3'd0;
  localparam logic [2:0]  REG_ANGLE_THIRTY  = 3'd1;
  localparam logic [2:0]  REG_ANGLE_ZERO    = 3'd2;
  localparam logic [2:0]  REG_DUTY_FULL     = 3'd3;
  localparam logic [2:0]  REG_DUTY_HALF     = 3'd4;
  localparam logic [2:0]  REG_DUTY_OFF      = 3'd5;
  localparam logic [2:0]  REG_SERVO_BASE    = 3'd6;
  localparam logic [2:0]  REG_SERIAL_GAIN   = 3'd7;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] angle_ninety_pulse;
    logic [15:0] angle_thirty_pulse;
    logic [15:0] angle_zero_pulse;
    logic [7:0]  duty_full;
    logic [7:0]  duty_half;
    logic [7:0]  duty_off;
    logic [15:0] servo_base;
    logic [7:0]  serial_gain;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic [15:0] servo_a_pulse;
    logic [15:0] servo_b_pulse;
    logic [7:0]  motor_a_duty;
    logic [7:0]  motor_b_duty;
    logic        direction;
    logic [1:0]  mode_now;
  } res_t;

  // Saturate a grown pulse sum at the limit
  function automatic logic [15:0] clip_pulse(input logic [16:0] v);
    logic [15:0] r;
    r = (v > {1'b0, PULSE_MAX}) ? PULSE_MAX : v[15:0];
    return r;
  endfunction

endpackage

FILE: rtl/rmpc_if.sv
// ----------------------------------------------------------------------------
// rmpc channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface rmpc_in_if;
  import rmpc_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface rmpc_out_if;
  import rmpc_pkg::*;
  logic        valid;
  logic        ready;
  logic [15:0] servo_a_pulse;
  logic [15:0] servo_b_pulse;
  logic [7:0]  motor_a_duty;
  logic [7:0]  motor_b_duty;
  logic        direction;
  logic [1:0]  mode_now;
  modport source (output valid, servo_a_pulse, servo_b_pulse, motor_a_duty, motor_b_duty,
                  direction, mode_now, input ready);
  modport sink   (input valid, servo_a_pulse, servo_b_pulse, motor_a_duty, motor_b_duty,
                  direction, mode_now, output ready);
endinterface

interface rmpc_cfg_if;
  import rmpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rover_mode_pwm_commander.sv
// ----------------------------------------------------------------------------
// rover_mode_pwm_commander
// Servo, motor and direction commander driven by ADC, serial and button words.
// ----------------------------------------------------------------------------
// Takes one input word per clock while the result is being taken, and returns
// one result word per input word, the servo pulses, motor duties, direction and
// mode after that event. A word is held in the input register, then the update
// logic writes the state registers, which double as the result register: the
// result word is presented once they are written. Sustained rate is one word
// per cycle while the result is taken, set by the single update stage; a
// stalled result holds the input register, and the input side keeps accepting
// as long as the result is being taken.
// Configuration writes are taken every cycle (cfg_ch.ready is tied high).
module rover_mode_pwm_commander (
  input  logic clk,
  input  logic rst_n,
  rmpc_in_if.sink    in_ch,
  rmpc_out_if.source out_ch,
  rmpc_cfg_if.sink   cfg_ch
);
  import rmpc_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  logic  out_valid_r;
  logic  step;
  res_t  res;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  rmpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Input register; the update fires when the result slot is free or being taken
  assign step        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (step) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.action    <= in_ch.action;
      item_r.data_byte <= in_ch.data_byte;
    end
  end

  // Event update and result registers
  rmpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.servo_a_pulse = res.servo_a_pulse;
  assign out_ch.servo_b_pulse = res.servo_b_pulse;
  assign out_ch.motor_a_duty  = res.motor_a_duty;
  assign out_ch.motor_b_duty  = res.motor_b_duty;
  assign out_ch.direction     = res.direction;
  assign out_ch.mode_now      = res.mode_now;

endmodule

FILE: rtl/rmpc_cfg.sv
// ----------------------------------------------------------------------------
// rmpc_cfg
// Configuration register file: preset pulses, preset duties, base and gain.
// ----------------------------------------------------------------------------
module rmpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [rmpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]                   wr_data,
  output rmpc_pkg::cfg_t                cfg
);
  import rmpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; 8-bit registers keep the low byte
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ANGLE_NINETY: cfg_nxt.angle_ninety_pulse = wr_data;
        REG_ANGLE_THIRTY: cfg_nxt.angle_thirty_pulse = wr_data;
        REG_ANGLE_ZERO:   cfg_nxt.angle_zero_pulse   = wr_data;
        REG_DUTY_FULL:    cfg_nxt.duty_full          = wr_data[7:0];
        REG_DUTY_HALF:    cfg_nxt.duty_half          = wr_data[7:0];
        REG_DUTY_OFF:     cfg_nxt.duty_off           = wr_data[7:0];
        REG_SERVO_BASE:   cfg_nxt.servo_base         = wr_data;
        REG_SERIAL_GAIN:  cfg_nxt.serial_gain        = wr_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_ninety_pulse <= 16'd4000;
      cfg_r.angle_thirty_pulse <= 16'd2600;
      cfg_r.angle_zero_pulse   <= 16'd2000;
      cfg_r.duty_full          <= 8'd255;
      cfg_r.duty_half          <= 8'd128;
      cfg_r.duty_off           <= 8'd0;
      cfg_r.servo_base         <= 16'd2000;
      cfg_r.serial_gain        <= 8'd22;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rmpc_core.sv
// ----------------------------------------------------------------------------
// rmpc_core
// Event update: ADC scan, serial command pairing, mode and direction, and
// the servo and motor registers that form the result word.
// ----------------------------------------------------------------------------
module rmpc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  rmpc_pkg::item_t item,
  input  rmpc_pkg::cfg_t  cfg,
  output rmpc_pkg::res_t  res
);
  import rmpc_pkg::*;

  logic [1:0]          mode_r,   mode_nxt;
  logic [SCAN_W-1:0]   scan_r,   scan_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [7:0]          rd_r   [SCAN_CHANNELS];
  logic [7:0]          rd_nxt [SCAN_CHANNELS];
  logic                phase_r,  phase_nxt;
  logic [7:0]          sel_r,    sel_nxt;
  logic                dir_r,    dir_nxt;
  logic [15:0]         srv_a_r,  srv_a_nxt;
  logic [15:0]         srv_b_r,  srv_b_nxt;
  logic [7:0]          mot_a_r,  mot_a_nxt;
  logic [7:0]          mot_b_r,  mot_b_nxt;

  // Readings of channels 0..3 after this event; absent channels read zero
  logic [7:0]        view [4];
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [16:0]       sum_a, sum_b;
  logic [15:0]       serial_prod;
  logic [16:0]       serial_sum;
  logic [15:0]       serial_pulse;

  // Scan, settle and stored readings
  always_comb begin
    scan_nxt   = scan_r;
    settle_nxt = settle_r;
    for (int i = 0; i < SCAN_CHANNELS; i++) begin
      rd_nxt[i] = rd_r[i];
    end
    if (item.action == ACT_ADC) begin
      if (settle_r != SETTLE_W'(SETTLE_SAMPLES)) begin
        settle_nxt = settle_r + 1'b1;
      end else begin
        rd_nxt[scan_r] = item.data_byte;
        scan_nxt       = (scan_r == SCAN_W'(SCAN_CHANNELS - 1)) ? '0 : scan_r + 1'b1;
        settle_nxt     = '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      view[k] = 8'd0;
    end
    for (int k = 0; k < SCAN_CHANNELS; k++) begin
      if (k < 4) view[k] = rd_nxt[k];
    end
  end

  // Analog servo pulses: base + reading * 7.843 (Q10, truncated)
  assign prod_a = PROD_W'(view[0]) * PROD_W'(SCALE_Q10);
  assign prod_b = PROD_W'(view[1]) * PROD_W'(SCALE_Q10);
  assign sum_a  = {1'b0, cfg.servo_base} + 17'(prod_a[PROD_W-1:SCALE_SHIFT]);
  assign sum_b  = {1'b0, cfg.servo_base} + 17'(prod_b[PROD_W-1:SCALE_SHIFT]);

  // Serial servo pulse: base + gain * value
  assign serial_prod  = 16'(cfg.serial_gain) * 16'(item.data_byte);
  assign serial_sum   = {1'b0, cfg.servo_base} + {1'b0, serial_prod};
  assign serial_pulse = clip_pulse(serial_sum);

  // Mode, command pairing, direction and output registers
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    sel_nxt   = sel_r;
    dir_nxt   = dir_r;
    srv_a_nxt = srv_a_r;
    srv_b_nxt = srv_b_r;
    mot_a_nxt = mot_a_r;
    mot_b_nxt = mot_b_r;

    case (item.action)
      ACT_SERIAL: begin
        if (!phase_r) begin
          sel_nxt   = item.data_byte;
          phase_nxt = 1'b1;
        end else begin
          // Value byte completes the pair: command applies once, here
          phase_nxt = 1'b0;
          if (mode_r == MODE_SERIAL) begin
            case (sel_r)
              SEL_SERVO_A: srv_a_nxt = serial_pulse;
              SEL_SERVO_B: srv_b_nxt = serial_pulse;
              SEL_MOTOR_A: mot_a_nxt = item.data_byte;
              SEL_MOTOR_B: mot_b_nxt = item.data_byte;
              SEL_DIR:     if (item.data_byte == VAL_TOGGLE) dir_nxt = ~dir_r;
              default:     ;
            endcase
          end else if (mode_r == MODE_PRESET && sel_r == SEL_DIR) begin
            case (item.data_byte)
              VAL_TOGGLE: dir_nxt = ~dir_r;
              VAL_PRE_PARK: begin
                srv_a_nxt = clip_pulse({1'b0, cfg.angle_ninety_pulse});
                srv_b_nxt = clip_pulse({1'b0, cfg.angle_zero_pulse});
                mot_a_nxt = cfg.duty_off;
                mot_b_nxt = cfg.duty_off;
              end
              VAL_PRE_TURN: begin
                srv_a_nxt = clip_pulse({1'b0, cfg.angle_thirty_pulse});
                srv_b_nxt = clip_pulse({1'b0, cfg.angle_ninety_pulse});
                mot_a_nxt = cfg.duty_off;
                mot_b_nxt = cfg.duty_off;
              end
              VAL_PRE_RIGHT: begin
                srv_a_nxt = clip_pulse({1'b0, cfg.angle_ninety_pulse});
                srv_b_nxt = clip_pulse({1'b0, cfg.angle_zero_pulse});
                mot_a_nxt = cfg.duty_full;
                mot_b_nxt = cfg.duty_half;
              end
              VAL_PRE_LEFT: begin
                srv_a_nxt = clip_pulse({1'b0, cfg.angle_ninety_pulse});
                srv_b_nxt = clip_pulse({1'b0, cfg.angle_zero_pulse});
                mot_a_nxt = cfg.duty_half;
                mot_b_nxt = cfg.duty_full;
              end
              default: ;
            endcase
          end
        end
      end
      ACT_MODE: mode_nxt = (mode_r >= MODE_SERIAL) ? MODE_ANALOG : mode_r + 1'b1;
      ACT_DIR:  dir_nxt  = ~dir_r;
      default:  ;
    endcase

    // Analog mode: outputs follow the readings after this event
    if (mode_nxt == MODE_ANALOG) begin
      srv_a_nxt = clip_pulse(sum_a);
      srv_b_nxt = clip_pulse(sum_b);
      mot_a_nxt = view[2];
      mot_b_nxt = view[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ANALOG;
      scan_r   <= '0;
      settle_r <= '0;
      phase_r  <= 1'b0;
      sel_r    <= 8'd0;
      dir_r    <= 1'b0;
      srv_a_r  <= 16'd0;
      srv_b_r  <= 16'd0;
      mot_a_r  <= 8'd0;
      mot_b_r  <= 8'd0;
      for (int i = 0; i < SCAN_CHANNELS; i++) begin
        rd_r[i] <= 8'd0;
      end
    end else if (step) begin
      mode_r   <= mode_nxt;
      scan_r   <= scan_nxt;
      settle_r <= settle_nxt;
      phase_r  <= phase_nxt;
      sel_r    <= sel_nxt;
      dir_r    <= dir_nxt;
      srv_a_r  <= srv_a_nxt;
      srv_b_r  <= srv_b_nxt;
      mot_a_r  <= mot_a_nxt;
      mot_b_r  <= mot_b_nxt;
      for (int i = 0; i < SCAN_CHANNELS; i++) begin
        rd_r[i] <= rd_nxt[i];
      end
    end
  end

  // The state registers are the result word
  assign res.servo_a_pulse = srv_a_r;
  assign res.servo_b_pulse = srv_b_r;
  assign res.motor_a_duty  = mot_a_r;
  assign res.motor_b_duty  = mot_b_r;
  assign res.direction     = dir_r;
  assign res.mode_now      = mode_r;

endmodule
